// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros: assertion helpers for the door state tracker
// Clocked on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked at every rising edge of aclk
`define DST_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// same-cycle implication
`define DST_ASSERT_IMPL(label, ante, cons, msg) \
    `DST_ASSERT(label, (ante) |-> (cons), msg)

// next-cycle implication
`define DST_ASSERT_NEXT(label, ante, cons, msg) \
    `DST_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ----- rtl/dst_pkg.sv -----
// ----------------------------------------------------------------------------
// dst_pkg: types, codes and report logic of the door state tracker
// Shared definitions for the tracker datapath and its output queue.
// ----------------------------------------------------------------------------
package dst_pkg;

    localparam int TIME_BITS  = 32;
    localparam int CFG_W      = 32;
    localparam int CMP_W      = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [CFG_W-1:0]     TRAVEL_RST         = CFG_W'(30000);
    localparam logic [CFG_W-1:0]     GAP_RST            = CFG_W'(1000);
    localparam logic [CFG_W-1:0]     ARM_RST            = CFG_W'(3000);

    typedef logic [TIME_BITS-1:0] time_t;

    typedef enum logic [2:0] {
        KIND_TICK    = 3'd0,
        KIND_SENSOR  = 3'd1,
        KIND_CMD     = 3'd2,
        KIND_CONNECT = 3'd3,
        KIND_LOST    = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        CMD_OPEN  = 2'd0,
        CMD_CLOSE = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_BAD   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        DOOR_CLOSED  = 3'd0,
        DOOR_OPEN    = 3'd1,
        DOOR_OPENING = 3'd2,
        DOOR_CLOSING = 3'd3,
        DOOR_STOPPED = 3'd4
    } door_t;

    typedef enum logic [2:0] {
        ST_NONE           = 3'd0,
        ST_ACCEPTED       = 3'd1,
        ST_NOT_ARMED      = 3'd2,
        ST_RATE_LIMITED   = 3'd3,
        ST_NOT_APPLICABLE = 3'd4,
        ST_RELAY_REFUSED  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        REG_TRAVEL_TIMEOUT = 2'd0,
        REG_COMMAND_GAP    = 2'd1,
        REG_ARM_DELAY      = 2'd2
    } reg_idx_t;

    typedef struct packed {
        kind_t kind;
        logic  door_closed;
        cmd_t  command;
        logic  relay_ok;
        logic  publish_ok;
    } item_t;

    typedef struct packed {
        logic    report_valid;
        door_t   door_state;
        logic    relay_pulse;
        logic    relay_force;
        status_t command_status;
        logic    last_result;
    } result_t;

    // door tracking and report dedup state
    typedef struct packed {
        logic  door_is_closed;
        logic  in_transit;
        logic  transit_up;
        logic  transit_from_closed;
        logic  halted;
        logic  halted_going_up;
        door_t reported_state;
        logic  first_report_done;
        logic  reported_closed;
        logic  report_pending;
        logic  link_up;
    } trk_t;

    typedef struct packed {
        trk_t  trk;
        logic  sent;
        door_t st;
    } rpt_t;

    // derive the door state, then send it unless deduplicated; with the link or publish down, mark it pending
    function automatic rpt_t report_state(trk_t s, logic send_always, logic pub_ok);
        rpt_t r;
        logic dc;
        logic changed;
        logic arrived;
        door_t st;
        r       = '{trk: s, sent: 1'b0, st: DOOR_CLOSED};
        dc      = s.door_is_closed;
        changed = (dc != s.transit_from_closed);
        arrived = (s.transit_up ? !dc : dc) && changed;
        if (s.in_transit) begin
            if (arrived) begin
                r.trk.in_transit = 1'b0;
                st = dc ? DOOR_CLOSED : DOOR_OPEN;
            end else begin
                st = s.transit_up ? DOOR_OPENING : DOOR_CLOSING;
            end
        end else if (s.halted) begin
            if (dc) begin
                r.trk.halted = 1'b0;
                st = DOOR_CLOSED;
            end else begin
                st = DOOR_STOPPED;
            end
        end else begin
            st = dc ? DOOR_CLOSED : DOOR_OPEN;
        end
        r.st = st;
        if (!(s.first_report_done && st == s.reported_state) &&
            (send_always || dc != s.reported_closed || s.report_pending)) begin
            if (s.link_up && pub_ok) begin
                r.trk.reported_closed   = dc;
                r.trk.report_pending    = 1'b0;
                r.trk.reported_state    = st;
                r.trk.first_report_done = 1'b1;
                r.sent                  = 1'b1;
            end else begin
                r.trk.report_pending = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic result_t mk_result(logic valid, door_t st, logic pulse,
                                          logic bypass, status_t status);
        result_t r;
        r.report_valid   = valid;
        r.door_state     = valid ? st : DOOR_CLOSED;
        r.relay_pulse    = pulse;
        r.relay_force    = bypass;
        r.command_status = status;
        r.last_result    = 1'b0;
        return r;
    endfunction

endpackage

// ----- rtl/door_state_tracker.sv -----
// ----------------------------------------------------------------------------
// door_state_tracker: single-button door state tracker
// Follows the door from ticks, switch reports, commands and link events and
// emits relay requests, command status and deduplicated state reports.
// ----------------------------------------------------------------------------
// Items land in an input register and are worked in one pass of logic into a
// four-deep result queue, so a new item can be taken every cycle while the
// queue has room for two results. A tick or connect can give two results,
// which leave the result port one after the other; other kinds give one or none.
// An item is held in the input register and its first result in the queue
// before that result leaves. Commands always give exactly one result; link
// loss and unknown kinds give none.
`include "assert_macros.svh"

module door_state_tracker (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // door_closed, command[1:0], relay_ok, publish_ok
    input  logic [2:0]  s_tuser,   // kind
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // report_valid, door_state[2:0], relay_pulse,
                                   // relay_force, command_status[2:0]
    output logic        m_tlast    // last_result
);

    // configuration registers
    logic [dst_pkg::CFG_W-1:0] travel_timeout_reg;
    logic [dst_pkg::CFG_W-1:0] command_gap_reg;
    logic [dst_pkg::CFG_W-1:0] arm_delay_reg;

    // input register
    logic           in_valid_reg;
    dst_pkg::item_t in_reg;
    dst_pkg::item_t item;

    // tracker state
    dst_pkg::trk_t  trk_reg, trk_next;
    dst_pkg::time_t time_reg, time_next;
    dst_pkg::time_t transit_began_reg, transit_began_next;
    dst_pkg::time_t connected_at_reg, connected_at_next;
    dst_pkg::time_t last_cmd_reg, last_cmd_next;
    logic           armed_reg, armed_next;

    // result queue
    dst_pkg::result_t               fifo_reg [dst_pkg::FIFO_DEPTH];
    logic [dst_pkg::PTR_W-1:0]      wr_ptr_reg, rd_ptr_reg, wr_ptr1;
    logic [dst_pkg::CNT_W-1:0]      cnt_reg;
    logic                           pop, proc, room;

    // datapath
    dst_pkg::time_t   t_now, conn_at, since_conn, since_began, since_cmd;
    dst_pkg::trk_t    s0, s1, s2, s2t, s3, stop_in, sc;
    dst_pkg::rpt_t    ra, rb, rc, rs;
    logic             is_connect, en_a, en_b, en_c, loop_en, arm_hit;
    logic             c0, c1, c2;
    logic             dc;
    logic             cmd_ok;
    dst_pkg::result_t cmd_res, res_first, res_second;
    logic [1:0]       n_res;

    assign item = in_reg;

    assign pop      = m_tvalid && m_tready;
    assign room     = (cnt_reg <= dst_pkg::CNT_W'(dst_pkg::FIFO_DEPTH - 2)) ||
                      (pop && cnt_reg == dst_pkg::CNT_W'(dst_pkg::FIFO_DEPTH - 1));
    assign proc     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || proc;
    assign wr_ptr1  = wr_ptr_reg + dst_pkg::PTR_W'(1);

    always_comb begin
        // ---- tick, sensor and connect path ----
        t_now      = (item.kind == dst_pkg::KIND_TICK) ? time_reg + dst_pkg::TIME_BITS'(1)
                                                        : time_reg;
        is_connect = (item.kind == dst_pkg::KIND_CONNECT) && !trk_reg.link_up;
        conn_at    = is_connect ? time_reg : connected_at_reg;

        s0 = trk_reg;
        if (item.kind == dst_pkg::KIND_TICK || item.kind == dst_pkg::KIND_SENSOR ||
            is_connect) begin
            s0.door_is_closed = item.door_closed;
        end
        if (is_connect) begin
            s0.link_up = 1'b1;
        end

        en_a = (item.kind == dst_pkg::KIND_SENSOR) || is_connect;
        ra   = dst_pkg::report_state(s0, is_connect, item.publish_ok);
        s1   = en_a ? ra.trk : s0;

        loop_en    = (item.kind == dst_pkg::KIND_TICK) || is_connect;
        since_conn = t_now - conn_at;
        arm_hit    = s1.link_up &&
                     (dst_pkg::CMP_W'(since_conn) >= dst_pkg::CMP_W'(arm_delay_reg));

        en_b = loop_en && s1.report_pending && s1.link_up;
        rb   = dst_pkg::report_state(s1, 1'b1, item.publish_ok);
        s2   = en_b ? rb.trk : s1;

        // transit timeout ends the move and falls back to the switch
        since_began = t_now - transit_began_reg;
        en_c = loop_en && s2.in_transit &&
               (dst_pkg::CMP_W'(since_began) > dst_pkg::CMP_W'(travel_timeout_reg));
        s2t            = s2;
        s2t.in_transit = 1'b0;
        rc = dst_pkg::report_state(s2t, 1'b1, item.publish_ok);
        s3 = en_c ? rc.trk : s2;

        c0 = en_a && ra.sent;
        c1 = en_b && rb.sent;
        c2 = en_c && rc.sent;

        // ---- command path ----
        dc                      = trk_reg.door_is_closed;
        stop_in                 = trk_reg;
        stop_in.halted_going_up = trk_reg.transit_up;
        stop_in.in_transit      = 1'b0;
        stop_in.halted          = 1'b1;
        rs = dst_pkg::report_state(stop_in, 1'b1, item.publish_ok);

        since_cmd          = time_reg - last_cmd_reg;
        sc                 = trk_reg;
        last_cmd_next      = last_cmd_reg;
        transit_began_next = transit_began_reg;
        cmd_ok             = 1'b0;
        cmd_res = dst_pkg::mk_result(1'b0, dst_pkg::DOOR_CLOSED, 1'b0, 1'b0,
                                     dst_pkg::ST_NOT_APPLICABLE);
        if (!armed_reg) begin
            cmd_res.command_status = dst_pkg::ST_NOT_ARMED;
        end else if (dst_pkg::CMP_W'(since_cmd) < dst_pkg::CMP_W'(command_gap_reg)) begin
            cmd_res.command_status = dst_pkg::ST_RATE_LIMITED;
        end else begin
            last_cmd_next = time_reg;
            unique case (item.command)
                dst_pkg::CMD_OPEN: begin
                    cmd_ok = (dc && !trk_reg.in_transit) ||
                             (trk_reg.halted && !trk_reg.halted_going_up);
                end
                dst_pkg::CMD_CLOSE: begin
                    cmd_ok = (!dc && !trk_reg.in_transit && !trk_reg.halted) ||
                             (trk_reg.halted && trk_reg.halted_going_up);
                end
                dst_pkg::CMD_STOP: begin
                    cmd_ok = trk_reg.in_transit;
                end
                default: begin
                    cmd_ok = 1'b0;
                end
            endcase
            if (cmd_ok && !item.relay_ok) begin
                cmd_res.command_status = dst_pkg::ST_RELAY_REFUSED;
            end else if (cmd_ok && item.command == dst_pkg::CMD_STOP) begin
                sc = rs.trk;
                cmd_res = dst_pkg::mk_result(rs.sent, rs.st, 1'b1, 1'b1,
                                             dst_pkg::ST_ACCEPTED);
            end else if (cmd_ok) begin
                // begin transit; the start report does not touch dedup memory
                sc.in_transit          = 1'b1;
                sc.transit_up          = (item.command == dst_pkg::CMD_OPEN);
                sc.transit_from_closed = dc;
                sc.halted              = 1'b0;
                transit_began_next     = time_reg;
                cmd_res = dst_pkg::mk_result(
                    trk_reg.link_up && item.publish_ok,
                    (item.command == dst_pkg::CMD_OPEN) ? dst_pkg::DOOR_OPENING
                                                         : dst_pkg::DOOR_CLOSING,
                    1'b1, 1'b0, dst_pkg::ST_ACCEPTED);
            end
        end

        // ---- select next state and results by kind ----
        trk_next          = trk_reg;
        time_next         = time_reg;
        connected_at_next = connected_at_reg;
        armed_next        = armed_reg;
        n_res             = 2'd0;
        res_first         = c0 ? dst_pkg::mk_result(1'b1, ra.st, 1'b0, 1'b0, dst_pkg::ST_NONE) :
                            c1 ? dst_pkg::mk_result(1'b1, rb.st, 1'b0, 1'b0, dst_pkg::ST_NONE)
                               : dst_pkg::mk_result(1'b1, rc.st, 1'b0, 1'b0, dst_pkg::ST_NONE);
        res_second        = (c0 && c1) ?
                            dst_pkg::mk_result(1'b1, rb.st, 1'b0, 1'b0, dst_pkg::ST_NONE) :
                            dst_pkg::mk_result(1'b1, rc.st, 1'b0, 1'b0, dst_pkg::ST_NONE);

        unique case (item.kind)
            dst_pkg::KIND_TICK: begin
                trk_next   = s3;
                time_next  = t_now;
                armed_next = armed_reg || arm_hit;
                n_res      = ((c0 && c1) || (c0 && c2) || (c1 && c2)) ? 2'd2 :
                             (c0 || c1 || c2) ? 2'd1 : 2'd0;
            end
            dst_pkg::KIND_SENSOR: begin
                trk_next = s1;
                n_res    = c0 ? 2'd1 : 2'd0;
            end
            dst_pkg::KIND_CMD: begin
                trk_next  = sc;
                n_res     = 2'd1;
                res_first = cmd_res;
            end
            dst_pkg::KIND_CONNECT: begin
                if (is_connect) begin
                    trk_next          = s3;
                    connected_at_next = time_reg;
                    armed_next        = arm_hit;
                    n_res             = ((c0 && c1) || (c0 && c2) || (c1 && c2)) ? 2'd2 :
                                        (c0 || c1 || c2) ? 2'd1 : 2'd0;
                end
            end
            dst_pkg::KIND_LOST: begin
                trk_next.link_up = 1'b0;
                armed_next       = 1'b0;
            end
            default: begin
                n_res = 2'd0;
            end
        endcase

        res_first.last_result  = (n_res == 2'd1);
        res_second.last_result = 1'b1;
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            travel_timeout_reg <= dst_pkg::TRAVEL_RST;
            command_gap_reg    <= dst_pkg::GAP_RST;
            arm_delay_reg      <= dst_pkg::ARM_RST;
        end else if (cfg_we) begin
            unique case (dst_pkg::reg_idx_t'(cfg_addr))
                dst_pkg::REG_TRAVEL_TIMEOUT: travel_timeout_reg <= cfg_wdata;
                dst_pkg::REG_COMMAND_GAP:    command_gap_reg    <= cfg_wdata;
                dst_pkg::REG_ARM_DELAY:      arm_delay_reg      <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg.kind        <= dst_pkg::kind_t'(s_tuser);
            in_reg.door_closed <= s_tdata[0];
            in_reg.command     <= dst_pkg::cmd_t'(s_tdata[2:1]);
            in_reg.relay_ok    <= s_tdata[3];
            in_reg.publish_ok  <= s_tdata[4];
        end
    end

    // tracker state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trk_reg <= '{door_is_closed: 1'b1, in_transit: 1'b0, transit_up: 1'b0,
                         transit_from_closed: 1'b1, halted: 1'b0,
                         halted_going_up: 1'b0, reported_state: dst_pkg::DOOR_CLOSED,
                         first_report_done: 1'b0, reported_closed: 1'b1,
                         report_pending: 1'b0, link_up: 1'b0};
            time_reg          <= '0;
            transit_began_reg <= '0;
            connected_at_reg  <= '0;
            last_cmd_reg      <= '0;
            armed_reg         <= 1'b0;
        end else if (proc) begin
            trk_reg           <= trk_next;
            time_reg          <= time_next;
            transit_began_reg <= (item.kind == dst_pkg::KIND_CMD) ? transit_began_next
                                                                  : transit_began_reg;
            connected_at_reg  <= connected_at_next;
            last_cmd_reg      <= (item.kind == dst_pkg::KIND_CMD) ? last_cmd_next
                                                                  : last_cmd_reg;
            armed_reg         <= armed_next;
        end
    end

    // result queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (proc) begin
                wr_ptr_reg <= wr_ptr_reg + dst_pkg::PTR_W'(n_res);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + dst_pkg::PTR_W'(1);
            end
            cnt_reg <= cnt_reg + (proc ? dst_pkg::CNT_W'(n_res) : '0)
                               - dst_pkg::CNT_W'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && n_res != 2'd0) begin
            fifo_reg[wr_ptr_reg] <= res_first;
        end
        if (proc && n_res == 2'd2) begin
            fifo_reg[wr_ptr1] <= res_second;
        end
    end

    assign m_tvalid = (cnt_reg != '0);
    assign m_tlast  = fifo_reg[rd_ptr_reg].last_result;
    assign m_tdata  = {7'd0,
                       fifo_reg[rd_ptr_reg].command_status,
                       fifo_reg[rd_ptr_reg].relay_force,
                       fifo_reg[rd_ptr_reg].relay_pulse,
                       fifo_reg[rd_ptr_reg].door_state,
                       fifo_reg[rd_ptr_reg].report_valid};

    // ---- assertions ----
    `DST_ASSERT(a_fifo_bound, cnt_reg <= dst_pkg::CNT_W'(dst_pkg::FIFO_DEPTH), "queue overrun")
    `DST_ASSERT(a_transit_halt, !(trk_reg.in_transit && trk_reg.halted), "moving and halted")
    `DST_ASSERT_IMPL(a_armed_link, armed_reg, trk_reg.link_up, "armed without link")
    `DST_ASSERT_IMPL(a_cmd_one, proc && item.kind == dst_pkg::KIND_CMD, n_res == 2'd1, "command result count")
    `DST_ASSERT_IMPL(a_lost_quiet, proc && item.kind == dst_pkg::KIND_LOST, n_res == 2'd0, "link loss gave a result")
    `DST_ASSERT_NEXT(a_tick_time, proc && item.kind == dst_pkg::KIND_TICK, time_reg == dst_pkg::TIME_BITS'($past(time_reg) + 1'b1), "tick did not advance time")

endmodule
